### rtl/core/conv3x3_image_filter_defines.svh
// Assertion helpers shared by the filter RTL.
`ifndef CONV3X3_IMAGE_FILTER_DEFINES_SVH
`define CONV3X3_IMAGE_FILTER_DEFINES_SVH

// same-cycle implication
`define C3F_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error("c3f assertion failed");

// next-cycle implication
`define C3F_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error("c3f assertion failed");

`endif

### rtl/core/c3f_pkg.sv
package c3f_pkg;

    localparam int WIDTH_W       = 11;
    localparam int HEIGHT_W      = 13;
    localparam int MODE_W        = 3;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 13;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  PAD_RAW = 8'd127;
    localparam logic [11:0] PAD_SM  = 12'd2032;
    // ceil(2^16 / 9), exact for the small sums used here
    localparam logic [12:0] RECIP9  = 13'd7282;

    localparam logic [MODE_W-1:0] MODE_EMBOSS  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BLUR    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SHARPEN = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GAUSS   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PREWITT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LOG     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

    typedef logic [7:0]  pix_t;
    typedef logic [11:0] sm_t;

    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic [MODE_W-1:0]   mode;
    } cfg_t;

    typedef struct packed {
        pix_t [8:0] raw;
        sm_t  [8:0] sm;
        logic       last;
    } win_item_t;

    function automatic logic [11:0] gauss_sum(input pix_t [8:0] p);
        logic [11:0] s;
        s = 12'(p[0]) + 12'(p[2]) + 12'(p[6]) + 12'(p[8])
          + ((12'(p[1]) + 12'(p[3]) + 12'(p[5]) + 12'(p[7])) << 1)
          + (12'(p[4]) << 2);
        return s;
    endfunction

endpackage

### rtl/core/c3f_pix_if.sv
interface c3f_pix_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] pixel_in;

    modport source (output valid, output kind, output pixel_in, input ready);
    modport sink   (input valid, input kind, input pixel_in, output ready);
endinterface

### rtl/core/c3f_res_if.sv
interface c3f_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic       frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

### rtl/core/c3f_cfg_if.sv
interface c3f_cfg_if;
    import c3f_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/conv3x3_image_filter.sv
// channel | dir | handshake     | payload
// pix     | in  | valid/ready   | kind, pixel_in
// res     | out | valid/ready   | pixel_out, frame_last
// cfg     | in  | valid/ready   | index, data (width, height, mode)
//
// One pixel item per clock sustained unless busy or held by the output; the front
// line-buffer pipeline is two stages (read the row memories, then shift windows
// and gather), the back adds two more (sums, then the multiply-by-reciprocal
// divide by nine, clamp and select, into the output register). First result
// appears W+1 items into a frame, 2W+2 in LoG mode. After reset and after every
// register write the block re-derives its row/column counters with a bit-serial
// divider, during which pix.ready and cfg.ready are low.
// A stalled output fills the four-entry window queue, then input stalls.
module conv3x3_image_filter #(
    parameter int MAX_WIDTH = c3f_pkg::MAX_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    c3f_pix_if.sink   pix,
    c3f_res_if.source res,
    c3f_cfg_if.sink   cfg
);
    import c3f_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [MODE_W-1:0]   mode_reg;
    cfg_t                cfg_cur;
    logic                cfg_wr, busy;

    logic              push, pop, q_empty;
    win_item_t         item, head;
    logic [QCNT_W-1:0] q_count;

    // register writes are taken only while the counters are settled
    assign cfg.ready = !busy;
    assign cfg_wr    = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_W'(1024);
            height_reg <= HEIGHT_W'(768);
            mode_reg   <= MODE_BLUR;
        end
        else if (cfg_wr)
        begin
            unique case (cfg.index)
                REG_WIDTH:  width_reg  <= cfg.data[WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= cfg.data[HEIGHT_W-1:0];
                REG_MODE:   mode_reg   <= cfg.data[MODE_W-1:0];
                default:    ;
            endcase
        end
    end

    assign cfg_cur.width  = width_reg;
    assign cfg_cur.height = height_reg;
    assign cfg_cur.mode   = mode_reg;

    // front: positions, line buffers, windows
    c3f_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (pix),
        .cfg     (cfg_cur),
        .cfg_wr  (cfg_wr),
        .q_count (q_count),
        .busy    (busy),
        .push    (push),
        .item    (item)
    );

    // gathered windows waiting for the arithmetic
    c3f_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (item),
        .pop   (pop),
        .head  (head),
        .empty (q_empty),
        .count (q_count)
    );

    // back: filter arithmetic and output register
    c3f_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .mode    (mode_reg),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .res     (res)
    );
endmodule

### rtl/core/c3f_div.sv
module c3f_div #(
    parameter int NW = 24,
    parameter int DW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [DW:0]   r2;
    logic          ge;

    // restoring division, one quotient bit per cycle
    assign r2 = {rem_reg, quo_reg[NW-1]};
    assign ge = r2 >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? DW'(r2 - {1'b0, den_reg}) : DW'(r2);
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;
endmodule

### rtl/core/c3f_front.sv
`include "conv3x3_image_filter_defines.svh"
module c3f_front #(
    parameter int MAX_WIDTH = c3f_pkg::MAX_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    c3f_pix_if.sink                    pix,
    input  c3f_pkg::cfg_t              cfg,
    input  logic                       cfg_wr,
    input  logic [c3f_pkg::QCNT_W-1:0] q_count,
    output logic                       busy,
    output logic                       push,
    output c3f_pkg::win_item_t         item
);
    import c3f_pkg::*;

    localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WMAX = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
    localparam int TW   = $clog2(WMAX * MAX_HEIGHT + 1);
    localparam int PW   = TW + 1;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TOTAL = 3'd1;
    localparam logic [2:0] PH_IP    = 3'd2;
    localparam logic [2:0] PH_S     = 3'd3;
    localparam logic [2:0] PH_Q     = 3'd4;

    // effective geometry
    logic [WIDTH_W-1:0]  w0, w_eff;
    logic [HEIGHT_W-1:0] h0, h_eff;
    logic [WIDTH_W+HEIGHT_W-1:0] prod;
    logic [PW-1:0] w1, lag;

    assign w0    = (cfg.width == '0) ? WIDTH_W'(1) : cfg.width;
    assign w_eff = (w0 > WIDTH_W'(WMAX)) ? WIDTH_W'(WMAX) : w0;
    assign h0    = (cfg.height == '0) ? HEIGHT_W'(1) : cfg.height;
    assign h_eff = (h0 > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT) : h0;
    assign prod  = (WIDTH_W+HEIGHT_W)'(w_eff) * (WIDTH_W+HEIGHT_W)'(h_eff);
    assign w1    = PW'(w_eff) + 1'b1;
    assign lag   = (cfg.mode == MODE_LOG) ? (w1 << 1) : w1;

    // position state
    logic [2:0]    phase_reg;
    logic [TW-1:0] total_reg;
    logic [PW-1:0] ip_reg, op_reg;
    logic [AW-1:0] in_col_reg;
    logic [AW-1:0] s_col_reg, q_col_reg;
    logic [PW-1:0] s_row_reg, q_row_reg;
    logic          s_v_reg, q_v_reg;

    logic          accept, last;
    logic [PW-1:0] ip_inc;
    logic          in_wrap, s_wrap, q_wrap;
    logic [7:0]    sample;

    assign busy   = phase_reg != PH_IDLE;
    assign pix.ready = !busy
        && ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(a_valid_reg)) < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept = pix.valid && pix.ready;
    assign ip_inc = ip_reg + 1'b1;
    assign last   = q_v_reg && ((op_reg + 1'b1) >= PW'(total_reg));
    assign in_wrap = (PW'(in_col_reg) + 1'b1) == PW'(w_eff);
    assign s_wrap  = (PW'(s_col_reg) + 1'b1) == PW'(w_eff);
    assign q_wrap  = (PW'(q_col_reg) + 1'b1) == PW'(w_eff);
    assign sample = (!pix.kind && (ip_reg < PW'(total_reg))) ? pix.pixel_in : PAD_RAW;

    // {col ok right/mid/left, row ok bot/mid/top}
    function automatic logic [5:0] edge_mask(input logic [PW-1:0] r,
                                             input logic [AW-1:0] c,
                                             input logic [WIDTH_W-1:0] w,
                                             input logic [HEIGHT_W-1:0] h);
        logic [5:0] m;
        m[0] = (PW'(r) >= PW'(1)) && (r <= PW'(h));
        m[1] = (r + PW'(1)) <= PW'(h);
        m[2] = (r + PW'(2)) <= PW'(h);
        m[3] = c != '0;
        m[4] = 1'b1;
        m[5] = (PW'(c) + PW'(2)) <= PW'(w);
        return m;
    endfunction

    // divider for re-deriving positions after reset or a register write
    logic          div_start, div_done;
    logic [PW-1:0] div_num, div_quo, s_num, q_num;
    logic [WIDTH_W-1:0] div_rem;

    assign s_num = (ip_reg >= w1)  ? ip_reg - w1  : '0;
    assign q_num = (ip_reg >= lag) ? ip_reg - lag : '0;
    assign div_start = (phase_reg == PH_TOTAL)
        || (div_done && ((phase_reg == PH_IP) || (phase_reg == PH_S)));
    assign div_num = (phase_reg == PH_TOTAL) ? ip_reg
                   : ((phase_reg == PH_IP) ? s_num : q_num);

    c3f_div #(.NW(PW), .DW(WIDTH_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (w_eff),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // stage A registers
    logic          a_valid_reg, a_emit_reg, a_last_reg, a_s_ok_reg;
    logic [AW-1:0] a_col_reg, a_s_col_reg;
    logic [7:0]    a_sample_reg;
    logic [5:0]    a_smask_reg, a_qmask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TOTAL;
            total_reg  <= '0;
            ip_reg     <= '0;
            op_reg     <= '0;
            in_col_reg <= '0;
            s_col_reg  <= '0;
            s_row_reg  <= '0;
            s_v_reg    <= 1'b0;
            q_col_reg  <= '0;
            q_row_reg  <= '0;
            q_v_reg    <= 1'b0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            if (cfg_wr)
            begin
                phase_reg <= PH_TOTAL;
            end
            else if (accept)
            begin
                if (last)
                begin
                    ip_reg     <= '0;
                    op_reg     <= '0;
                    in_col_reg <= '0;
                    s_v_reg    <= 1'b0;
                    q_v_reg    <= 1'b0;
                end
                else
                begin
                    ip_reg     <= ip_inc;
                    in_col_reg <= in_wrap ? '0 : in_col_reg + 1'b1;
                    if (q_v_reg)
                        op_reg <= op_reg + 1'b1;
                    if (s_v_reg)
                    begin
                        s_col_reg <= s_wrap ? '0 : s_col_reg + 1'b1;
                        if (s_wrap)
                            s_row_reg <= s_row_reg + 1'b1;
                    end
                    else if (ip_inc == w1)
                    begin
                        s_v_reg   <= 1'b1;
                        s_col_reg <= '0;
                        s_row_reg <= '0;
                    end
                    if (q_v_reg)
                    begin
                        q_col_reg <= q_wrap ? '0 : q_col_reg + 1'b1;
                        if (q_wrap)
                            q_row_reg <= q_row_reg + 1'b1;
                    end
                    else if (ip_inc == lag)
                    begin
                        q_v_reg   <= 1'b1;
                        q_col_reg <= '0;
                        q_row_reg <= '0;
                    end
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_TOTAL:
                    begin
                        total_reg <= TW'(prod);
                        phase_reg <= PH_IP;
                    end
                    PH_IP:
                    begin
                        if (div_done)
                        begin
                            in_col_reg <= AW'(div_rem);
                            phase_reg  <= PH_S;
                        end
                    end
                    PH_S:
                    begin
                        if (div_done)
                        begin
                            s_col_reg <= AW'(div_rem);
                            s_row_reg <= div_quo;
                            s_v_reg   <= ip_reg >= w1;
                            phase_reg <= PH_Q;
                        end
                    end
                    PH_Q:
                    begin
                        if (div_done)
                        begin
                            q_col_reg <= AW'(div_rem);
                            q_row_reg <= div_quo;
                            q_v_reg   <= ip_reg >= lag;
                            phase_reg <= PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_reg <= PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_col_reg    <= in_col_reg;
            a_s_col_reg  <= s_col_reg;
            a_sample_reg <= sample;
            a_s_ok_reg   <= s_v_reg;
            a_emit_reg   <= q_v_reg;
            a_last_reg   <= last;
            a_smask_reg  <= edge_mask(s_row_reg, s_col_reg, w_eff, h_eff);
            a_qmask_reg  <= edge_mask(q_row_reg, q_col_reg, w_eff, h_eff);
        end
    end

    // line buffers: each entry holds {older row, newer row}
    logic [15:0] raw_mem [MAX_WIDTH];
    logic [23:0] sm_mem  [MAX_WIDTH];
    logic [15:0] raw_q_reg, raw_fwd_data_reg, raw_rd, raw_wdata;
    logic [23:0] sm_q_reg, sm_fwd_data_reg, sm_rd, sm_wdata;
    logic        raw_fwd_reg, sm_fwd_reg, raw_we, sm_we;

    assign raw_we = a_valid_reg;
    assign sm_we  = a_valid_reg && a_s_ok_reg;

    always_ff @(posedge clk)
    begin
        if (raw_we)
            raw_mem[a_col_reg] <= raw_wdata;
        raw_q_reg        <= raw_mem[in_col_reg];
        raw_fwd_reg      <= raw_we && (a_col_reg == in_col_reg);
        raw_fwd_data_reg <= raw_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
            sm_mem[a_s_col_reg] <= sm_wdata;
        sm_q_reg        <= sm_mem[s_col_reg];
        sm_fwd_reg      <= sm_we && (a_s_col_reg == s_col_reg);
        sm_fwd_data_reg <= sm_wdata;
    end

    // stage B: window shift, Gaussian pass, gather
    pix_t [8:0] raw_win_reg, raw_new, raw_s;
    sm_t  [8:0] sm_win_reg, sm_new;
    logic [11:0] g;

    assign raw_rd    = raw_fwd_reg ? raw_fwd_data_reg : raw_q_reg;
    assign raw_wdata = {raw_rd[7:0], a_sample_reg};
    assign sm_rd     = sm_fwd_reg ? sm_fwd_data_reg : sm_q_reg;
    assign sm_wdata  = {sm_rd[11:0], g};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            raw_new[i*3]   = raw_win_reg[i*3+1];
            raw_new[i*3+1] = raw_win_reg[i*3+2];
        end
        raw_new[2] = raw_rd[15:8];
        raw_new[5] = raw_rd[7:0];
        raw_new[8] = a_sample_reg;
        for (int k = 0; k < 9; k++)
            raw_s[k] = (a_smask_reg[k/3] && a_smask_reg[3 + k%3]) ? raw_new[k] : PAD_RAW;
        g = gauss_sum(raw_s);
        if (a_s_ok_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sm_new[i*3]   = sm_win_reg[i*3+1];
                sm_new[i*3+1] = sm_win_reg[i*3+2];
            end
            sm_new[2] = sm_rd[23:12];
            sm_new[5] = sm_rd[11:0];
            sm_new[8] = g;
        end
        else
        begin
            sm_new = sm_win_reg;
        end
        for (int k = 0; k < 9; k++)
        begin
            item.raw[k] = (a_qmask_reg[k/3] && a_qmask_reg[3 + k%3]) ? raw_new[k] : PAD_RAW;
            item.sm[k]  = (a_qmask_reg[k/3] && a_qmask_reg[3 + k%3]) ? sm_new[k] : PAD_SM;
        end
        item.last = a_last_reg;
    end

    assign push = a_valid_reg && a_emit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
            begin
                raw_win_reg[k] <= PAD_RAW;
                sm_win_reg[k]  <= PAD_SM;
            end
        end
        else if (a_valid_reg)
        begin
            for (int k = 0; k < 9; k++)
            begin
                raw_win_reg[k] <= a_last_reg ? PAD_RAW : raw_new[k];
                sm_win_reg[k]  <= a_last_reg ? PAD_SM : sm_new[k];
            end
        end
    end

    `C3F_ASSERT_IMP(a_col_in_range, !busy, PW'(in_col_reg) < PW'(w_eff))
    `C3F_ASSERT_IMP(a_emit_after_smooth, q_v_reg && !busy, s_v_reg)
endmodule

### rtl/core/c3f_queue.sv
`include "conv3x3_image_filter_defines.svh"
module c3f_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  c3f_pkg::win_item_t         din,
    input  logic                       pop,
    output c3f_pkg::win_item_t         head,
    output logic                       empty,
    output logic [c3f_pkg::QCNT_W-1:0] count
);
    import c3f_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    win_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= din;
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = count_reg == '0;
    assign count = count_reg;

    `C3F_ASSERT_IMP(a_no_overflow, push && !pop, count_reg < QCNT_W'(QUEUE_DEPTH))
endmodule

### rtl/core/c3f_back.sv
`include "conv3x3_image_filter_defines.svh"
module c3f_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [c3f_pkg::MODE_W-1:0] mode,
    input  c3f_pkg::win_item_t         head,
    input  logic                       q_empty,
    output logic                       pop,
    c3f_res_if.source                  res
);
    import c3f_pkg::*;

    function automatic logic [7:0] clamp8(input logic signed [17:0] v);
        if (v < 0)
            return 8'd0;
        if (v > 18'sd255)
            return 8'd255;
        return v[7:0];
    endfunction

    logic adv2, load1;
    logic s1_valid_reg, s1_last_reg;
    logic [11:0]        s1_sum_reg, s1_gauss_reg;
    logic signed [9:0]  s1_emb_reg;
    logic signed [12:0] s1_sharp_reg;
    logic signed [10:0] s1_gy_reg, s1_gx_reg;
    logic signed [16:0] s1_lap_reg;
    logic out_valid_reg, out_last_reg;
    logic [7:0] out_pix_reg;

    assign adv2  = !out_valid_reg || res.ready;
    assign load1 = !s1_valid_reg || adv2;
    assign pop   = load1 && !q_empty;

    // stage 1: window sums
    logic signed [17:0] pr [9];
    logic signed [17:0] ps [9];
    logic signed [17:0] sum, gy, gx, lap;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            pr[k] = signed'({10'd0, head.raw[k]});
            ps[k] = signed'({6'd0, head.sm[k]});
        end
        sum = pr[0] + pr[1] + pr[2] + pr[3] + pr[4] + pr[5] + pr[6] + pr[7] + pr[8];
        gy  = (pr[6] + pr[7] + pr[8]) - (pr[0] + pr[1] + pr[2]);
        gx  = (pr[0] + pr[3] + pr[6]) - (pr[2] + pr[5] + pr[8]);
        lap = (ps[4] <<< 3) - (ps[0] + ps[1] + ps[2] + ps[3] + ps[5] + ps[6] + ps[7] + ps[8]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (load1)
            s1_valid_reg <= !q_empty;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_last_reg  <= head.last;
            s1_sum_reg   <= 12'(sum);
            s1_gauss_reg <= gauss_sum(head.raw);
            s1_emb_reg   <= 10'(pr[8] - pr[0] + 18'sd127);
            s1_sharp_reg <= 13'((pr[4] <<< 3) + pr[4] - sum);
            s1_gy_reg    <= 11'(gy);
            s1_gx_reg    <= 11'(gx);
            s1_lap_reg   <= 17'(lap);
        end
    end

    // stage 2: divide by nine, clamp, select
    logic [28:0] blur_p, sharp_p;
    logic [7:0]  cg, v;

    always_comb
    begin
        blur_p  = 29'(s1_sum_reg) * 29'(RECIP9);
        sharp_p = 29'(s1_sharp_reg[11:0]) * 29'(RECIP9);
        cg      = clamp8(18'(s1_gy_reg));
        unique case (mode)
            MODE_EMBOSS:  v = clamp8(18'(s1_emb_reg));
            MODE_SHARPEN: v = (s1_sharp_reg < 0) ? 8'd0 : sharp_p[23:16];
            MODE_GAUSS:   v = s1_gauss_reg[11:4];
            MODE_PREWITT: v = clamp8(signed'({10'd0, cg}) + 18'(s1_gx_reg));
            MODE_LOG:     v = (s1_lap_reg < 0) ? 8'd0 : clamp8(18'(s1_lap_reg) >>> 4);
            default:      v = blur_p[23:16];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv2)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            out_pix_reg  <= v;
            out_last_reg <= s1_last_reg;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.pixel_out  = out_pix_reg;
    assign res.frame_last = out_last_reg;

    `C3F_ASSERT_IMP(a_pop_nonempty, pop, !q_empty)
    `C3F_ASSERT_NXT(a_stage1_held, s1_valid_reg && !adv2, s1_valid_reg)
endmodule

### sim/conv3x3_image_filter_tb.sv
module conv3x3_image_filter_tb;
    import c3f_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    c3f_pix_if pix_ch ();
    c3f_res_if res_ch ();
    c3f_cfg_if cfg_ch ();

    conv3x3_image_filter uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #6 clk = ~clk;

    // One filtered pixel the block still owes us.
    typedef struct {
        logic [7:0] px;
        bit         last;
    } out_pixel_t;

    out_pixel_t pending_pixels[$];

    // Directed row: one 1x1 frame, pixel plus drain ticks.
    // want < 0 means "take it from the predictor".
    typedef struct {
        int mode;
        bit kind;
        int px;
        int want;
    } dir_row_t;

    localparam int N_DIR = 13;
    dir_row_t dir_rows [N_DIR] = '{
        '{MODE_EMBOSS,  1'b0, 0,   127},
        '{MODE_EMBOSS,  1'b0, 255, 127},
        '{MODE_BLUR,    1'b0, 127, 127},
        '{MODE_BLUR,    1'b1, 0,   127},   // drain tick standing in for the frame pixel
        '{MODE_SHARPEN, 1'b0, 255, 113},
        '{MODE_SHARPEN, 1'b0, 0,   0},
        '{MODE_GAUSS,   1'b0, 255, 159},
        '{MODE_PREWITT, 1'b0, 0,   0},
        '{MODE_PREWITT, 1'b0, 255, 0},
        '{MODE_LOG,     1'b0, 255, -1},
        '{MODE_LOG,     1'b0, 0,   -1},
        '{6,            1'b0, 127, 127},   // spare codes behave as blur
        '{7,            1'b0, 0,   112}
    };

    // ---------------- predictor state ----------------
    int         reg_width  = 1024;
    int         reg_height = 768;
    int         reg_mode   = MODE_BLUR;
    logic [7:0]  raw_row_a [1024];
    logic [7:0]  raw_row_b [1024];
    logic [11:0] sm_row_a  [1024];
    logic [11:0] sm_row_b  [1024];
    int         win [2][9];        // [0] raw pixels, [1] gaussian sixteenths
    int         cells [9];         // gathered, padded window
    int         in_pos  = 0;
    int         out_pos = 0;
    bit         frame_done;
    int         forced_px = -1;    // typed expectation for a directed row

    int  mismatches = 0;
    int  checked    = 0;
    int  sent       = 0;
    int  frames     = 0;
    bit  quiet      = 1'b0;        // suppress idling on both sides

    function automatic int clamp8(int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    function automatic void reset_windows();
        for (int i = 0; i < 9; i++)
        begin
            win[0][i] = 127;
            win[1][i] = 2032;
        end
    endfunction

    // push a new column into the right edge of a window
    function automatic void shift_col(int sel, int top, int mid, int bot);
        for (int i = 0; i < 3; i++)
        begin
            win[sel][i*3+0] = win[sel][i*3+1];
            win[sel][i*3+1] = win[sel][i*3+2];
        end
        win[sel][2] = top;
        win[sel][5] = mid;
        win[sel][8] = bot;
    endfunction

    // copy window centered at position q; cells outside the frame read as pad
    function automatic void gather(int sel, int q, int w, int h, int pad);
        int r;
        int c;
        r = q / w;
        c = q % w;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                cells[i*3+j] = (r + i >= 1 && r + i <= h && c + j >= 1 && c + j <= w)
                             ? win[sel][i*3+j] : pad;
    endfunction

    function automatic int weighted_121();
        return cells[0] + 2*cells[1] + cells[2] + 2*cells[3] + 4*cells[4]
             + 2*cells[5] + cells[6] + 2*cells[7] + cells[8];
    endfunction

    function automatic int filter_raw(int mode);
        int s;
        int t;
        int gy;
        int gx;
        s = 0;
        for (int i = 0; i < 9; i++)
            s += cells[i];
        case (mode)
            MODE_EMBOSS:  return clamp8(cells[8] - cells[0] + 127);
            MODE_SHARPEN:
            begin
                t = 9*cells[4] - s;
                return (t < 0) ? 0 : clamp8(t / 9);
            end
            MODE_GAUSS:   return clamp8(weighted_121() >> 4);
            MODE_PREWITT:
            begin
                gy = (cells[6] + cells[7] + cells[8]) - (cells[0] + cells[1] + cells[2]);
                gx = (cells[0] + cells[3] + cells[6]) - (cells[2] + cells[5] + cells[8]);
                return clamp8(clamp8(gy) + gx);
            end
            default:      return clamp8(s / 9);
        endcase
    endfunction

    // advance the filter by one accepted item; queue the pixel it yields, if any
    function automatic void filter_step(bit kind, int px);
        int w;
        int h;
        int total;
        int ip;
        int x;
        int smp;
        int a;
        int b;
        int s;
        int g;
        int lag;
        int q;
        int v;
        int lap;
        bit last;
        out_pixel_t e;
        w = (reg_width < 1) ? 1 : ((reg_width > 1024) ? 1024 : reg_width);
        h = (reg_height < 1) ? 1 : ((reg_height > 4096) ? 4096 : reg_height);
        total = w * h;
        ip = in_pos;
        smp = (!kind && ip < total) ? px : 127;
        x = ip % w;
        a = raw_row_a[x];
        b = raw_row_b[x];
        shift_col(0, a, b, smp);
        raw_row_a[x] = b[7:0];
        raw_row_b[x] = smp[7:0];
        // gaussian pass, lagging one row and one pixel
        if (ip >= w + 1)
        begin
            s = ip - (w + 1);
            gather(0, s, w, h, 127);
            g = weighted_121();
            x = s % w;
            a = sm_row_a[x];
            b = sm_row_b[x];
            shift_col(1, a, b, g);
            sm_row_a[x] = b[11:0];
            sm_row_b[x] = g[11:0];
        end
        in_pos = ip + 1;
        lag = (reg_mode == MODE_LOG) ? 2*(w + 1) : w + 1;
        if (ip >= lag)
        begin
            q = ip - lag;
            if (reg_mode == MODE_LOG)
            begin
                gather(1, q, w, h, 2032);
                lap = 8*cells[4];
                for (int i = 0; i < 9; i++)
                    if (i != 4)
                        lap -= cells[i];
                v = (lap < 0) ? 0 : clamp8(lap >>> 4);
            end
            else
            begin
                gather(0, q, w, h, 127);
                v = filter_raw(reg_mode);
            end
            last = (out_pos + 1 >= total);
            e.px = (forced_px >= 0) ? forced_px[7:0] : v[7:0];
            e.last = last;
            pending_pixels.push_back(e);
            out_pos++;
            if (last)
            begin
                in_pos = 0;
                out_pos = 0;
                reset_windows();
                frame_done = 1'b1;
                frames++;
            end
        end
    endfunction

    // ---------------- driver side ----------------
    // Handshakes are sampled at the falling edge, where everything is settled,
    // and counted at the following rising edge.

    task automatic send_item(bit kind, int px);
        bit acc;
        if (!quiet && $urandom_range(99) < 34)
        begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.kind     <= kind;
        pix_ch.pixel_in <= px[7:0];
        do
        begin
            @(negedge clk);
            acc = pix_ch.ready;
            @(posedge clk);
        end
        while (!acc);
        sent++;
        filter_step(kind, px);
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        bit acc;
        pix_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data[CFG_DATA_W-1:0];
        do
        begin
            @(negedge clk);
            acc = cfg_ch.ready;
            @(posedge clk);
        end
        while (!acc);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_WIDTH:  reg_width  = data & 'h7FF;
            REG_HEIGHT: reg_height = data & 'h1FFF;
            REG_MODE:   reg_mode   = data & 'h7;
            default: ;
        endcase
    endtask

    task automatic setup(int w, int h, int mode);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_MODE, mode);
    endtask

    // One whole frame: pixels, occasionally a drain tick inside; then drain
    // ticks, occasionally a stray pixel, until the frame's last result is due.
    task automatic run_frame();
        int w;
        int h;
        int n;
        int px;
        w = (reg_width < 1) ? 1 : ((reg_width > 1024) ? 1024 : reg_width);
        h = (reg_height < 1) ? 1 : ((reg_height > 4096) ? 4096 : reg_height);
        n = 0;
        frame_done = 1'b0;
        while (!frame_done)
        begin
            case ($urandom_range(7))
                0:       px = 0;
                1:       px = 255;
                default: px = $urandom_range(255);
            endcase
            if (n < w*h)
                send_item($urandom_range(99) < 5, px);
            else
                send_item($urandom_range(99) >= 10, px);
            n++;
        end
    endtask

    // ---------------- result side ----------------
    initial
    begin : sink_side
        bit         v;
        bit         r;
        logic [7:0] got_px;
        bit         got_last;
        out_pixel_t e;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            v = res_ch.valid;
            r = res_ch.ready;
            got_px = res_ch.pixel_out;
            got_last = res_ch.frame_last;
            @(posedge clk);
            if (v && r)
            begin
                checked++;
                if (pending_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: pixel_out=%0d frame_last=%0b",
                                 got_px, got_last);
                end
                else
                begin
                    e = pending_pixels.pop_front();
                    if (got_px !== e.px || got_last !== e.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch on item %0d: pixel_out exp %0d got %0d, frame_last exp %0b got %0b",
                                     checked, e.px, got_px, e.last, got_last);
                    end
                end
            end
            res_ch.ready <= quiet || ($urandom_range(99) >= 34);
        end
    end

    // ---------------- main sequence ----------------
    initial
    begin : stimulus
        int w;
        int h;
        pix_ch.valid    = 1'b0;
        pix_ch.kind     = 1'b0;
        pix_ch.pixel_in = 8'd0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_WIDTH;
        cfg_ch.data     = '0;
        for (int i = 0; i < 1024; i++)
        begin
            raw_row_a[i] = 8'd0;
            raw_row_b[i] = 8'd0;
            sm_row_a[i]  = 12'd0;
            sm_row_b[i]  = 12'd0;
        end
        reset_windows();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 1x1 frames, every mode and code, extremes of the pixel
        write_reg(REG_WIDTH, 1);
        write_reg(REG_HEIGHT, 1);
        for (int i = 0; i < N_DIR; i++)
        begin
            write_reg(REG_MODE, dir_rows[i].mode);
            forced_px = dir_rows[i].want;
            frame_done = 1'b0;
            send_item(dir_rows[i].kind, dir_rows[i].px);
            while (!frame_done)
                send_item(1'b1, 0);
            forced_px = -1;
        end

        // register extremes: zero and out-of-range values are clamped
        setup(0, 0, MODE_LOG);
        run_frame();
        setup(2047, 1, MODE_BLUR);
        run_frame();
        setup(1024, 2, MODE_LOG);
        run_frame();
        setup(1, 8191, MODE_SHARPEN);
        run_frame();
        setup(3, 4096, MODE_EMBOSS);
        run_frame();

        // random small frames, ten in every forty without any idling
        while (sent < 16000)
        begin
            quiet = (frames % 40) >= 30;
            w = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            setup(w, h, $urandom_range(7));
            run_frame();
            if (sent > 7000 && frames > 60)
                break;
        end
        quiet = 1'b0;
        pix_ch.valid <= 1'b0;

        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("covered %0d input items over %0d frames, %0d results checked",
                 sent, frames, checked);
        $display("all six filters plus spare mode codes, sizes from 1x1 to 1024-wide and 4096-tall");
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #(12 * 3000000);
        $display("timeout waiting for results");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
